[hw/rtl/sparse_markov_chain_sampler_defines.svh]
// assertion macros shared by the rtl
`ifndef SPARSE_MARKOV_CHAIN_SAMPLER_DEFINES_SVH
`define SPARSE_MARKOV_CHAIN_SAMPLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smcs assertion failed");

// next-cycle implication, checked outside reset
`define SMCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smcs assertion failed");

`endif

[hw/rtl/smcs_pkg.sv]
`default_nettype none
package smcs_pkg;
    localparam int STATES_DEF = 256;
    localparam int WIDTH_DEF  = 16;

    localparam logic [2:0] CMD_LOAD_TAU    = 3'd0;
    localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd1;
    localparam logic [2:0] CMD_LOAD_SLOT   = 3'd2;
    localparam logic [2:0] CMD_LOAD_COUNT  = 3'd3;
    localparam logic [2:0] CMD_START       = 3'd4;
    localparam logic [2:0] CMD_NEXT        = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LOADED  = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;
    localparam logic [1:0] ST_NOSTART = 2'd3;

    localparam logic [0:0] CFG_STATES = 1'd0;
    localparam logic [0:0] CFG_WIDTH  = 1'd1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_CNT  = 10'b00_0000_0010,
        S_CHK  = 10'b00_0000_0100,
        S_SUM  = 10'b00_0000_1000,
        S_MUL0 = 10'b00_0001_0000,
        S_MUL1 = 10'b00_0010_0000,
        S_MUL2 = 10'b00_0100_0000,
        S_SCAN = 10'b00_1000_0000,
        S_TAU  = 10'b01_0000_0000,
        S_RES  = 10'b10_0000_0000
    } t_state;
endpackage
`default_nettype wire

[hw/rtl/smcs_ram.sv]
`default_nettype none
module smcs_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/smcs_mul.sv]
`default_nettype none
module smcs_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 64'(i_a) * 64'(i_b);
    end
endmodule
`default_nettype wire

[hw/rtl/sparse_markov_chain_sampler.sv]
`default_nettype none
// sparse markov chain sampler
// command channel: start with i_command and its fields; an item is taken when
// start is high and busy is low. loads (0..3) write the tables; they and
// unknown commands report status 1 in the next cycle without raising busy.
// start (4) sums the weight table (order N = min(number_of_states, STATES)),
// forms the threshold on the shared 32x32 multiplier and scans the weights
// again to pick the next state. next (5) reads the row count, sums and scans
// the row slots, or reports failure once the count is read and rejected. busy
// drops in the result cycle, so the next beat can be taken right then. both
// scans stream one memory read a cycle through registered-read rams.
// results: o_valid strobes for one cycle with o_tau_value, o_sampled_state
// and o_status; the receiver cannot stall, the block never waits on it.
// config: i_cfg_we/i_cfg_index/i_cfg_data, to be written only while idle;
// the user must keep to this, the block itself does not enforce it.
// reset: synchronous, active low; clears trajectory and failure state and
// config to 256 states and 16 slots. table contents are unknown until loaded.
module sparse_markov_chain_sampler #(
    parameter int STATES = smcs_pkg::STATES_DEF,
    parameter int WIDTH  = smcs_pkg::WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [8:0]         i_cfg_data,
    input  wire logic               start,
    input  wire logic [2:0]         i_command,
    input  wire logic [7:0]         i_state_index,
    input  wire logic [3:0]         i_slot_index,
    input  wire logic [31:0]        i_entry_value,
    input  wire logic [7:0]         i_target_state,
    input  wire logic [31:0]        i_uniform_draw,
    output logic                    busy,
    output logic                    o_valid,
    output logic signed [31:0]      o_tau_value,
    output logic [7:0]              o_sampled_state,
    output logic [1:0]              o_status
);
    `include "sparse_markov_chain_sampler_defines.svh"

    localparam int SA    = $clog2(STATES);
    localparam int SLOTS = STATES * WIDTH;
    localparam int SLW   = $clog2(SLOTS);
    localparam int CURW  = (SA > 8) ? SA : 8;
    localparam int CW    = ($clog2(STATES + 1) > 9) ? $clog2(STATES + 1) : 9;
    localparam int TW    = 32 + ((SA > 5) ? SA : 5);

    smcs_pkg::t_state r_state;
    logic [8:0]       r_nos;
    logic [4:0]       r_rw;
    logic [CURW-1:0]  r_cur, r_last;
    logic             r_active, r_failed, r_start_mode, r_pend, r_bad;
    logic [CW-1:0]    r_idx, r_didx, r_lim, r_n;
    logic [TW-1:0]    r_total, r_cum, r_thr;
    logic [31:0]      r_draw, r_p0hi;
    logic             r_valid;
    logic [31:0]      r_tau;
    logic [7:0]       r_st;
    logic [1:0]       r_status;

    logic            w_accept, w_si_ok, w_sl_ok;
    logic [CW-1:0]   w_eff_order;
    logic [8:0]      w_eff_width;
    logic [SA-1:0]   w_waddr;
    logic [SLW-1:0]  w_slot_waddr, w_slot_raddr;
    logic [31:0]     w_weight, w_tau, w_prob, w_item, w_mul_b;
    logic [4:0]      w_cnt, w_cnt_wdata;
    logic [7:0]      w_tgt;
    logic [63:0]     w_prod;
    logic [TW-1:0]   w_cum_n;
    logic [CURW-1:0] w_cand;

    assign busy     = (r_state != smcs_pkg::S_IDLE);
    assign w_accept = start && !busy;
    assign w_si_ok  = int'(i_state_index) < STATES;
    assign w_sl_ok  = int'(i_slot_index) < WIDTH;
    assign w_waddr  = SA'(i_state_index);
    assign w_slot_waddr = SLW'(i_state_index) * SLW'(WIDTH) + SLW'(i_slot_index);
    assign w_slot_raddr = SLW'(r_cur) * SLW'(WIDTH) + SLW'(r_idx);
    assign w_cnt_wdata  = (i_entry_value > 32'd31) ? 5'd31 : i_entry_value[4:0];

    assign w_eff_order = (CW'(r_nos) < CW'(STATES)) ? CW'(r_nos) : CW'(STATES);
    assign w_eff_width = (9'(r_rw) < 9'(WIDTH)) ? 9'(r_rw) : 9'(WIDTH);

    assign w_item  = r_start_mode ? w_weight : w_prob;
    assign w_cum_n = r_cum + TW'(w_item);
    assign w_cand  = r_start_mode ? CURW'(r_didx) : CURW'(w_tgt);
    assign w_mul_b = (r_state == smcs_pkg::S_MUL1) ? 32'(r_total[TW-1:32]) : r_total[31:0];

    smcs_ram #(.DW(32), .DEPTH(STATES)) u_tau (
        .i_clk(i_clk),
        .i_we(w_accept && i_command == smcs_pkg::CMD_LOAD_TAU && w_si_ok),
        .i_waddr(w_waddr), .i_wdata(i_entry_value),
        .i_raddr(SA'(r_cur)), .o_rdata(w_tau)
    );
    smcs_ram #(.DW(32), .DEPTH(STATES)) u_weight (
        .i_clk(i_clk),
        .i_we(w_accept && i_command == smcs_pkg::CMD_LOAD_WEIGHT && w_si_ok),
        .i_waddr(w_waddr), .i_wdata(i_entry_value),
        .i_raddr(r_idx[SA-1:0]), .o_rdata(w_weight)
    );
    smcs_ram #(.DW(5), .DEPTH(STATES)) u_count (
        .i_clk(i_clk),
        .i_we(w_accept && i_command == smcs_pkg::CMD_LOAD_COUNT && w_si_ok),
        .i_waddr(w_waddr), .i_wdata(w_cnt_wdata),
        .i_raddr(SA'(r_cur)), .o_rdata(w_cnt)
    );
    smcs_ram #(.DW(32), .DEPTH(SLOTS)) u_prob (
        .i_clk(i_clk),
        .i_we(w_accept && i_command == smcs_pkg::CMD_LOAD_SLOT && w_si_ok && w_sl_ok),
        .i_waddr(w_slot_waddr), .i_wdata(i_entry_value),
        .i_raddr(w_slot_raddr), .o_rdata(w_prob)
    );
    smcs_ram #(.DW(8), .DEPTH(SLOTS)) u_target (
        .i_clk(i_clk),
        .i_we(w_accept && i_command == smcs_pkg::CMD_LOAD_SLOT && w_si_ok && w_sl_ok),
        .i_waddr(w_slot_waddr), .i_wdata(i_target_state),
        .i_raddr(w_slot_raddr), .o_rdata(w_tgt)
    );

    smcs_mul u_mul (
        .i_clk(i_clk), .i_a(r_draw), .i_b(w_mul_b), .o_p(w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smcs_pkg::S_IDLE;
            r_nos    <= 9'd256;
            r_rw     <= 5'd16;
            r_cur    <= '0;
            r_active <= 1'b0;
            r_failed <= 1'b0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == smcs_pkg::CFG_STATES) begin
                    r_nos <= i_cfg_data;
                end else begin
                    r_rw <= i_cfg_data[4:0];
                end
            end
            case (r_state)
                smcs_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_draw <= i_uniform_draw;
                        r_tau  <= '0;
                        r_st   <= '0;
                        if (i_command == smcs_pkg::CMD_START) begin
                            r_active     <= 1'b1;
                            r_failed     <= 1'b0;
                            r_start_mode <= 1'b1;
                            r_lim        <= w_eff_order;
                            r_n          <= w_eff_order;
                            r_idx        <= '0;
                            r_pend       <= 1'b0;
                            r_total      <= '0;
                            r_bad        <= 1'b0;
                            r_state      <= smcs_pkg::S_SUM;
                        end else if (i_command == smcs_pkg::CMD_NEXT) begin
                            if (!r_active) begin
                                r_valid  <= 1'b1;
                                r_status <= smcs_pkg::ST_NOSTART;
                            end else if (r_failed) begin
                                r_valid  <= 1'b1;
                                r_status <= smcs_pkg::ST_FAIL;
                            end else begin
                                r_start_mode <= 1'b0;
                                r_n          <= w_eff_order;
                                r_state      <= smcs_pkg::S_CNT;
                            end
                        end else begin
                            r_valid  <= 1'b1;
                            r_status <= smcs_pkg::ST_LOADED;
                        end
                    end
                end
                smcs_pkg::S_CNT: begin
                    r_state <= smcs_pkg::S_CHK;
                end
                smcs_pkg::S_CHK: begin
                    if (w_cnt == 5'd0 || 9'(w_cnt) > w_eff_width) begin
                        r_failed <= 1'b1;
                        r_valid  <= 1'b1;
                        r_status <= smcs_pkg::ST_FAIL;
                        r_state  <= smcs_pkg::S_IDLE;
                    end else begin
                        r_lim   <= CW'(w_cnt);
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_total <= '0;
                        r_bad   <= 1'b0;
                        r_state <= smcs_pkg::S_SUM;
                    end
                end
                smcs_pkg::S_SUM: begin
                    if (r_pend) begin
                        r_total <= r_total + TW'(w_item);
                        if (!r_start_mode && CW'(w_tgt) >= r_n) begin
                            r_bad <= 1'b1;
                        end
                    end
                    if (r_idx < r_lim) begin
                        r_idx  <= r_idx + CW'(1);
                        r_didx <= r_idx;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (!r_pend && r_idx >= r_lim) begin
                        if (r_total == '0 || r_bad) begin
                            r_failed <= 1'b1;
                            r_valid  <= 1'b1;
                            r_status <= smcs_pkg::ST_FAIL;
                            r_state  <= smcs_pkg::S_IDLE;
                        end else begin
                            r_state <= smcs_pkg::S_MUL0;
                        end
                    end
                end
                smcs_pkg::S_MUL0: begin
                    r_state <= smcs_pkg::S_MUL1;
                end
                smcs_pkg::S_MUL1: begin
                    r_p0hi  <= w_prod[63:32];
                    r_state <= smcs_pkg::S_MUL2;
                end
                smcs_pkg::S_MUL2: begin
                    // floor(draw * total / 2^32), compared against the running sum
                    r_thr   <= TW'(w_prod) + TW'(r_p0hi);
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_cum   <= '0;
                    r_state <= smcs_pkg::S_SCAN;
                end
                smcs_pkg::S_SCAN: begin
                    if (r_idx < r_lim) begin
                        r_idx  <= r_idx + CW'(1);
                        r_didx <= r_idx;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_last <= w_cand;
                        r_cum  <= w_cum_n;
                        if (r_thr < w_cum_n) begin
                            r_cur   <= w_cand;
                            r_state <= smcs_pkg::S_TAU;
                        end
                    end else if (r_idx >= r_lim) begin
                        r_cur   <= r_last;
                        r_state <= smcs_pkg::S_TAU;
                    end
                end
                smcs_pkg::S_TAU: begin
                    r_state <= smcs_pkg::S_RES;
                end
                smcs_pkg::S_RES: begin
                    r_valid  <= 1'b1;
                    r_status <= smcs_pkg::ST_OK;
                    r_tau    <= w_tau;
                    r_st     <= r_cur[7:0];
                    r_state  <= smcs_pkg::S_IDLE;
                end
                default: begin
                    r_state <= smcs_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_tau_value     = r_tau;
    assign o_sampled_state = r_st;
    assign o_status        = r_status;

    `SMCS_ASSERT_NXT(a_accept_answers, w_accept, busy || o_valid)
    `SMCS_ASSERT_IMP(a_fail_needs_start, r_failed, r_active)
    `SMCS_ASSERT_IMP(a_ok_needs_start, o_valid && o_status == smcs_pkg::ST_OK, r_active && !r_failed)
    `SMCS_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(r_state))
endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int NSTATE = 256;
    localparam int NSLOT = 16;
    localparam longint LIMIT = 5000000;

    typedef struct packed {
        logic [31:0] tau;
        logic [7:0]  state;
        logic [1:0]  status;
    } sample_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = smcs_pkg::CFG_STATES;
    logic [8:0]  i_cfg_data = '0;
    logic        start = 1'b0;
    logic [2:0]  i_command = smcs_pkg::CMD_LOAD_TAU;
    logic [7:0]  i_state_index = '0;
    logic [3:0]  i_slot_index = '0;
    logic [31:0] i_entry_value = '0;
    logic [7:0]  i_target_state = '0;
    logic [31:0] i_uniform_draw = '0;
    logic        busy;
    logic        o_valid;
    logic signed [31:0] o_tau_value;
    logic [7:0]  o_sampled_state;
    logic [1:0]  o_status;

    sparse_markov_chain_sampler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .start(start), .i_command(i_command), .i_state_index(i_state_index),
        .i_slot_index(i_slot_index), .i_entry_value(i_entry_value),
        .i_target_state(i_target_state), .i_uniform_draw(i_uniform_draw),
        .busy(busy), .o_valid(o_valid), .o_tau_value(o_tau_value),
        .o_sampled_state(o_sampled_state), .o_status(o_status)
    );

    // shadow of the chain tables and trajectory
    logic [31:0] tau_mem[NSTATE];
    logic [31:0] weight_mem[NSTATE];
    logic [4:0]  count_mem[NSTATE];
    logic [31:0] prob_mem[NSTATE*NSLOT];
    logic [7:0]  target_mem[NSTATE*NSLOT];
    logic [7:0]  cur_state = '0;
    logic        walking = 1'b0;
    logic        failed = 1'b0;
    int unsigned order_reg = 256;
    int unsigned width_reg = 16;
    // states below this have all their slots loaded; others keep count zero
    int unsigned rows_ready = 0;

    sample_t     expected_samples[$];
    int          errors = 0;
    longint      cycles = 0;
    int          idle_pct = 0;

    initial forever #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && o_valid) begin
            if (expected_samples.size() == 0) begin
                report("result with nothing pending");
            end else begin
                want = expected_samples.pop_front();
                if (o_status !== want.status)
                    report($sformatf("status %0d want %0d", o_status, want.status));
                if (o_sampled_state !== want.state)
                    report($sformatf("state %0d want %0d", o_sampled_state, want.state));
                if (o_tau_value !== want.tau)
                    report($sformatf("tau %h want %h", o_tau_value, want.tau));
            end
        end
    end

    function automatic int unsigned eff_order();
        return order_reg < NSTATE ? order_reg : NSTATE;
    endfunction

    function automatic int unsigned eff_width();
        return width_reg < NSLOT ? width_reg : NSLOT;
    endfunction

    // inverse cdf: first index with draw * total < cum * 2^32
    function automatic int unsigned inverse_cdf(input bit on_row, input int unsigned off,
                                                input int unsigned n, input logic [63:0] total,
                                                input logic [31:0] draw);
        logic [63:0] cum;
        logic [95:0] lhs;
        cum = '0;
        lhs = 96'(draw) * 96'(total);
        for (int unsigned i = 0; i < n; i++) begin
            cum += on_row ? prob_mem[off+i] : weight_mem[i];
            if (lhs < (96'(cum) << 32)) return i;
        end
        return n - 1;
    endfunction

    function automatic sample_t walk_step(input logic [2:0] cmd, input logic [7:0] si,
                                          input logic [3:0] sl, input logic [31:0] val,
                                          input logic [7:0] tgt, input logic [31:0] draw);
        sample_t r;
        logic [63:0] total;
        int unsigned n, cnt, off, k;
        bit bad;
        r = '{tau: '0, state: '0, status: smcs_pkg::ST_LOADED};
        total = '0;
        n = eff_order();
        case (cmd)
            smcs_pkg::CMD_LOAD_TAU: tau_mem[si] = val;
            smcs_pkg::CMD_LOAD_WEIGHT: weight_mem[si] = val;
            smcs_pkg::CMD_LOAD_COUNT: count_mem[si] = val > 31 ? 5'd31 : val[4:0];
            smcs_pkg::CMD_LOAD_SLOT: begin
                prob_mem[si*NSLOT+sl] = val;
                target_mem[si*NSLOT+sl] = tgt;
            end
            smcs_pkg::CMD_START: begin
                for (int unsigned i = 0; i < n; i++) total += weight_mem[i];
                walking = 1'b1;
                if (total == 0) begin
                    failed = 1'b1;
                    r.status = smcs_pkg::ST_FAIL;
                end else begin
                    failed = 1'b0;
                    cur_state = 8'(inverse_cdf(1'b0, 0, n, total, draw));
                    r = '{tau: tau_mem[cur_state], state: cur_state, status: smcs_pkg::ST_OK};
                end
            end
            smcs_pkg::CMD_NEXT: begin
                if (!walking) begin
                    r.status = smcs_pkg::ST_NOSTART;
                end else if (failed) begin
                    r.status = smcs_pkg::ST_FAIL;
                end else begin
                    cnt = count_mem[cur_state];
                    off = cur_state * NSLOT;
                    bad = (cnt == 0 || cnt > eff_width());
                    if (!bad) begin
                        for (int unsigned i = 0; i < cnt; i++) begin
                            if (target_mem[off+i] >= n) bad = 1'b1;
                            total += prob_mem[off+i];
                        end
                        if (total == 0) bad = 1'b1;
                    end
                    if (bad) begin
                        failed = 1'b1;
                        r.status = smcs_pkg::ST_FAIL;
                    end else begin
                        k = inverse_cdf(1'b1, off, cnt, total, draw);
                        cur_state = target_mem[off+k];
                        r = '{tau: tau_mem[cur_state], state: cur_state,
                              status: smcs_pkg::ST_OK};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one beat and hold it until taken; caller is at a rising edge
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] si, input logic [3:0] sl,
                             input logic [31:0] val, input logic [7:0] tgt,
                             input logic [31:0] draw);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_state_index <= si;
        i_slot_index <= sl;
        i_entry_value <= val;
        i_target_state <= tgt;
        i_uniform_draw <= draw;
        do @(posedge i_clk); while (busy);
        expected_samples.push_back(walk_step(cmd, si, sl, val, tgt, draw));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [8:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == smcs_pkg::CFG_STATES) order_reg = data;
        else width_reg = data[4:0];
    endtask

    task automatic load_slot(input int unsigned s, input int unsigned j, input int unsigned n);
        logic [31:0] p;
        p = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
        send_item(smcs_pkg::CMD_LOAD_SLOT, 8'(s), 4'(j), p, 8'($urandom_range(0, n - 1)),
                  $urandom);
    endtask

    // a state whose slots are all loaded
    function automatic logic [7:0] ready_state();
        return 8'($urandom_range(0, rows_ready - 1));
    endfunction

    // give states below upto well formed rows and nonzero weights
    task automatic build_chain(input int unsigned upto);
        int unsigned n, w;
        n = eff_order() == 0 ? 1 : eff_order();
        w = eff_width() == 0 ? 1 : eff_width();
        for (int unsigned s = 0; s < upto; s++) begin
            send_item(smcs_pkg::CMD_LOAD_TAU, 8'(s), 4'($urandom), $urandom, 8'($urandom),
                      $urandom);
            send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'(s), 4'($urandom),
                      $urandom_range(1, 32'hffff_ffff), 8'($urandom), $urandom);
            send_item(smcs_pkg::CMD_LOAD_COUNT, 8'(s), 4'($urandom), $urandom_range(1, w),
                      8'($urandom), $urandom);
            for (int unsigned j = 0; j < NSLOT; j++) begin
                send_item(smcs_pkg::CMD_LOAD_SLOT, 8'(s), 4'(j),
                          $urandom_range(1, 32'hffff_ffff),
                          8'($urandom_range(0, n - 1)), $urandom);
            end
        end
        if (upto > rows_ready) rows_ready = upto;
    endtask

    task automatic random_item();
        int unsigned c, n, w;
        n = eff_order() == 0 ? 1 : eff_order();
        w = eff_width() == 0 ? 1 : eff_width();
        c = $urandom_range(0, 99);
        if (c < 8) begin
            send_item(smcs_pkg::CMD_LOAD_TAU, 8'($urandom), 4'($urandom), $urandom,
                      8'($urandom), $urandom);
        end else if (c < 18) begin
            send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'($urandom), 4'($urandom),
                      ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom, 8'($urandom),
                      $urandom);
        end else if (c < 40) begin
            if ($urandom_range(0, 19) == 0)
                send_item(smcs_pkg::CMD_LOAD_SLOT, 8'($urandom), 4'($urandom), $urandom,
                          8'($urandom), $urandom);
            else
                load_slot($urandom_range(0, n - 1), $urandom_range(0, NSLOT - 1), n);
        end else if (c < 50) begin
            case ($urandom_range(0, 9))
                0: send_item(smcs_pkg::CMD_LOAD_COUNT, 8'($urandom), 4'($urandom), 32'd0,
                             8'($urandom), $urandom);
                1: send_item(smcs_pkg::CMD_LOAD_COUNT, ready_state(), 4'($urandom),
                             $urandom, 8'($urandom), $urandom);
                2: send_item(smcs_pkg::CMD_LOAD_COUNT, ready_state(), 4'($urandom),
                             $urandom_range(0, 31), 8'($urandom), $urandom);
                default: send_item(smcs_pkg::CMD_LOAD_COUNT, ready_state(), 4'($urandom),
                                   $urandom_range(1, w), 8'($urandom), $urandom);
            endcase
        end else if (c < 60) begin
            send_item(smcs_pkg::CMD_START, 8'($urandom), 4'($urandom), $urandom,
                      8'($urandom), $urandom);
        end else if (c < 96) begin
            send_item(smcs_pkg::CMD_NEXT, 8'($urandom), 4'($urandom), $urandom,
                      8'($urandom), $urandom);
        end else begin
            send_item(c[0] ? CMD_SPARE_A : CMD_SPARE_B, 8'($urandom), 4'($urandom),
                      $urandom, 8'($urandom), $urandom);
        end
    endtask

    task automatic test_next_before_start();
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_NEXT, 8'hff, 4'hf, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
    endtask

    // every state gets a tau and a weight; rows start empty
    task automatic test_fill_tables();
        for (int unsigned s = 0; s < NSTATE; s++) begin
            send_item(smcs_pkg::CMD_LOAD_TAU, 8'(s), 4'($urandom), $urandom, 8'($urandom),
                      $urandom);
            send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'(s), 4'($urandom), $urandom,
                      8'($urandom), $urandom);
            send_item(smcs_pkg::CMD_LOAD_COUNT, 8'(s), 4'($urandom), 32'd0, 8'($urandom),
                      $urandom);
        end
    endtask

    task automatic test_corner_cases();
        write_cfg(smcs_pkg::CFG_STATES, 9'd2);
        write_cfg(smcs_pkg::CFG_WIDTH, 9'd2);
        // zero start total, then sticky failure
        send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'd1, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_WEIGHT, 8'd1, 4'd0, 32'hffff_ffff, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_TAU, 8'd1, 4'd0, 32'h8000_0000, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_TAU, 8'd0, 4'd0, 32'h7fff_ffff, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'hffff_ffff);
        // count wider than the row, then zero count
        send_item(smcs_pkg::CMD_LOAD_COUNT, 8'd1, 4'd0, 32'd3, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_COUNT, 8'd1, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'h8000_0000);
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        // saturated count, target out of order, zero row total
        send_item(smcs_pkg::CMD_LOAD_COUNT, 8'd1, 4'd0, 32'hffff_ffff, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_COUNT, 8'd1, 4'd0, 32'd2, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_SLOT, 8'd1, 4'd0, 32'd5, 8'd200, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_SLOT, 8'd1, 4'd1, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_LOAD_SLOT, 8'd1, 4'd0, 32'd0, 8'd1, 32'd0);
        send_item(smcs_pkg::CMD_START, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
        send_item(smcs_pkg::CMD_NEXT, 8'd0, 4'd0, 32'd0, 8'd0, 32'hffff_ffff);
        send_item(CMD_SPARE_A, 8'hff, 4'hf, 32'hffff_ffff, 8'hff, 32'hffff_ffff);
        send_item(CMD_SPARE_B, 8'd0, 4'd0, 32'd0, 8'd0, 32'd0);
    endtask

    task automatic test_random_walk(input logic [8:0] order, input logic [8:0] width,
                                    input int pct, input int count, input int rows);
        write_cfg(smcs_pkg::CFG_STATES, order);
        write_cfg(smcs_pkg::CFG_WIDTH, width);
        build_chain(rows);
        send_item(smcs_pkg::CMD_START, 8'($urandom), 4'($urandom), $urandom, 8'($urandom),
                  $urandom);
        idle_pct = pct;
        for (int i = 0; i < count; i++) random_item();
        idle_pct = 0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_next_before_start();
        test_fill_tables();
        test_corner_cases();
        test_random_walk(9'd256, 9'd16, 0, 60, 4);
        test_random_walk(9'd5, 9'd3, 71, 60, 5);
        test_random_walk(9'($urandom_range(2, 8)), 9'($urandom_range(1, 16)), 15, 90, 6);
        test_random_walk(9'd1, 9'd1, 0, 60, 1);
        test_random_walk(9'd0, 9'd0, 71, 40, 0);
        test_random_walk(9'h1ff, 9'd31, 71, 60, 0);
        test_random_walk(9'd3, 9'd16, 15, 60, 3);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/smcs_pkg.sv
hw/rtl/smcs_ram.sv
hw/rtl/smcs_mul.sv
hw/rtl/sparse_markov_chain_sampler.sv
test/tb_top.sv
